>>> design/pr3d_pkg.sv
`default_nettype none

package pr3d_pkg;

    // coordinate formats
    localparam int COORD_W = 16;
    localparam int INTER_W = COORD_W + 2;
    localparam int COEF_W = 18;
    localparam int PROD_W = INTER_W + COEF_W;
    localparam int SUM_W = PROD_W + 1;
    localparam int FRAC_W = 14;

    // angle registers and apb port
    localparam int ANGLE_W = 16;
    localparam int NUM_ANGLES = 3;
    localparam int ANGLE_IDX_W = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [ANGLE_IDX_W-1:0] REG_ANGLE_Z = 2'd0;
    localparam logic [ANGLE_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
    localparam logic [ANGLE_IDX_W-1:0] REG_ANGLE_X = 2'd2;

    // cordic
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 4;
    localparam int CORDIC_W = 33;
    localparam int CZ_W = 25;
    localparam int COEF_SHIFT = 16;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 33'sd652032874;
    localparam logic signed [CORDIC_W-1:0] COEF_ROUND = 33'sd32768;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_in;
        logic signed [COORD_W-1:0] y_in;
        logic signed [COORD_W-1:0] z_in;
    } point_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
    } point_out_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] cos_q;
        logic signed [COEF_W-1:0] sin_q;
    } coef_t;

    // arctangent per cordic step, 2^24 units per turn
    function automatic logic signed [CZ_W-1:0] atan_val(input logic [STEP_W-1:0] step);
        logic signed [CZ_W-1:0] v;
        case (step)
            4'd0:    v = 25'sd2097152;
            4'd1:    v = 25'sd1238021;
            4'd2:    v = 25'sd654136;
            4'd3:    v = 25'sd332050;
            4'd4:    v = 25'sd166669;
            4'd5:    v = 25'sd83416;
            4'd6:    v = 25'sd41718;
            4'd7:    v = 25'sd20860;
            4'd8:    v = 25'sd10430;
            4'd9:    v = 25'sd5215;
            4'd10:   v = 25'sd2608;
            4'd11:   v = 25'sd1304;
            4'd12:   v = 25'sd652;
            4'd13:   v = 25'sd326;
            4'd14:   v = 25'sd163;
            4'd15:   v = 25'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // clamp to the signed coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [INTER_W-1:0] v
    );
        logic signed [INTER_W-1:0] hi;
        logic signed [INTER_W-1:0] lo;
        logic signed [COORD_W-1:0] r;
        hi = {{(INTER_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            r = hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/pr3d_sincos.sv
`default_nettype none

module pr3d_sincos (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               recalc,
    input  logic [pr3d_pkg::ANGLE_W-1:0] angle_z,
    input  logic [pr3d_pkg::ANGLE_W-1:0] angle_y,
    input  logic [pr3d_pkg::ANGLE_W-1:0] angle_x,
    output pr3d_pkg::coef_t          coef_z,
    output pr3d_pkg::coef_t          coef_y,
    output pr3d_pkg::coef_t          coef_x,
    output logic                     busy
);
    import pr3d_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } sc_state_t;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

    sc_state_t state_reg, state_next;
    logic [2:0] pending_reg, pending_next;
    logic [2:0] pend_clear;
    logic [ANGLE_IDX_W-1:0] cur_reg, cur_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic neg_reg, neg_next;
    logic signed [CORDIC_W-1:0] cx_reg, cx_next;
    logic signed [CORDIC_W-1:0] cy_reg, cy_next;
    logic signed [CZ_W-1:0] cz_reg, cz_next;
    coef_t coef_reg [NUM_ANGLES];
    logic coef_we;
    coef_t coef_new;

    logic [ANGLE_IDX_W-1:0] sel_idx;
    logic [2:0] sel_onehot;
    logic [ANGLE_W-1:0] a_sel;
    logic a_neg;
    logic [ANGLE_W-1:0] a_fold;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [CZ_W-1:0] at;
    logic signed [CORDIC_W-1:0] cos_raw, sin_raw;
    logic signed [COEF_W-1:0] cos_v, sin_v;

    // lowest pending angle goes first
    always_comb
    begin
        if (pending_reg[0])
        begin
            sel_idx = REG_ANGLE_Z;
            sel_onehot = 3'b001;
            a_sel = angle_z;
        end
        else if (pending_reg[1])
        begin
            sel_idx = REG_ANGLE_Y;
            sel_onehot = 3'b010;
            a_sel = angle_y;
        end
        else
        begin
            sel_idx = REG_ANGLE_X;
            sel_onehot = 3'b100;
            a_sel = angle_x;
        end
    end

    // fold into a quarter turn either side of zero
    assign a_neg = a_sel[ANGLE_W-1] ^ a_sel[ANGLE_W-2];
    assign a_fold = {a_sel[ANGLE_W-1] ^ a_neg, a_sel[ANGLE_W-2:0]};

    assign dx = cy_reg >>> step_reg;
    assign dy = cx_reg >>> step_reg;
    assign at = atan_val(step_reg);

    assign cos_raw = cx_reg + COEF_ROUND;
    assign sin_raw = cy_reg + COEF_ROUND;
    assign cos_v = COEF_W'(signed'(cos_raw[CORDIC_W-1:COEF_SHIFT]));
    assign sin_v = COEF_W'(signed'(sin_raw[CORDIC_W-1:COEF_SHIFT]));
    assign coef_new.cos_q = neg_reg ? -cos_v : cos_v;
    assign coef_new.sin_q = neg_reg ? -sin_v : sin_v;

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        step_next = step_reg;
        neg_next = neg_reg;
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        pend_clear = '0;
        coef_we = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pending_reg != '0)
                begin
                    cur_next = sel_idx;
                    pend_clear = sel_onehot;
                    neg_next = a_neg;
                    cx_next = CORDIC_START;
                    cy_next = '0;
                    cz_next = CZ_W'(signed'({a_fold, 8'b0}));
                    step_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!cz_reg[CZ_W-1])
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    cz_next = cz_reg - at;
                end
                else
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    cz_next = cz_reg + at;
                end
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                coef_we = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a write during a run only re-queues the angle
    assign pending_next = (pending_reg & ~pend_clear) | recalc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pending_reg <= 3'b111;
            cur_reg <= REG_ANGLE_Z;
            step_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pending_reg <= pending_next;
            cur_reg <= cur_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        cz_reg <= cz_next;
        if (coef_we)
        begin
            coef_reg[cur_reg] <= coef_new;
        end
    end

    assign coef_z = coef_reg[REG_ANGLE_Z];
    assign coef_y = coef_reg[REG_ANGLE_Y];
    assign coef_x = coef_reg[REG_ANGLE_X];
    assign busy = (pending_reg != '0) || (state_reg != ST_IDLE);

endmodule

`default_nettype wire

>>> design/pr3d_rotate.sv
`default_nettype none

module pr3d_rotate (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              src_valid,
    input  logic signed [pr3d_pkg::INTER_W-1:0] src_p,
    input  logic signed [pr3d_pkg::INTER_W-1:0] src_q,
    input  logic signed [pr3d_pkg::INTER_W-1:0] src_o,
    input  pr3d_pkg::coef_t                   coef,
    output logic                              dst_valid,
    output logic signed [pr3d_pkg::INTER_W-1:0] dst_p,
    output logic signed [pr3d_pkg::INTER_W-1:0] dst_q,
    output logic signed [pr3d_pkg::INTER_W-1:0] dst_o
);
    import pr3d_pkg::*;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (FRAC_W - 1);

    // product stage
    logic valid_a_reg;
    logic signed [PROD_W-1:0] pc_reg, qs_reg, ps_reg, qc_reg;
    logic signed [PROD_W-1:0] pc_next, qs_next, ps_next, qc_next;
    logic signed [INTER_W-1:0] o_a_reg;

    // sum and round stage
    logic valid_b_reg;
    logic signed [SUM_W-1:0] np_sum, nq_sum;
    logic signed [INTER_W-1:0] p_b_reg, q_b_reg, o_b_reg;
    logic signed [INTER_W-1:0] p_b_next, q_b_next;

    assign pc_next = PROD_W'(src_p) * PROD_W'(coef.cos_q);
    assign qs_next = PROD_W'(src_q) * PROD_W'(coef.sin_q);
    assign ps_next = PROD_W'(src_p) * PROD_W'(coef.sin_q);
    assign qc_next = PROD_W'(src_q) * PROD_W'(coef.cos_q);

    assign np_sum = SUM_W'(pc_reg) - SUM_W'(qs_reg) + ROUND_HALF;
    assign nq_sum = SUM_W'(ps_reg) + SUM_W'(qc_reg) + ROUND_HALF;
    // floor shift by the fraction width
    assign p_b_next = np_sum[FRAC_W +: INTER_W];
    assign q_b_next = nq_sum[FRAC_W +: INTER_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= src_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg <= pc_next;
        qs_reg <= qs_next;
        ps_reg <= ps_next;
        qc_reg <= qc_next;
        o_a_reg <= src_o;
        p_b_reg <= p_b_next;
        q_b_reg <= q_b_next;
        o_b_reg <= o_a_reg;
    end

    assign dst_valid = valid_b_reg;
    assign dst_p = p_b_reg;
    assign dst_q = q_b_reg;
    assign dst_o = o_b_reg;

endmodule

`default_nettype wire

>>> design/point_rotate_3d_zyx_unit.sv
`default_nettype none

// point rotation engine, euler angles applied z then y then x. a word on
// point (signed q1.14 x, y, z) is taken at a clock edge with start high and
// busy low; one word per cycle may enter. the rotated, saturated point then
// shows on result for exactly one cycle with done high; the receiver cannot
// stall it, so it must take every word as it comes. the pipeline has two
// stages per axis (multiply, then sum and round) plus an output saturation
// register. sine and cosine of each angle come from a shared iterative
// cordic: after reset, and after every write to an angle register over apb,
// busy stays high while the sine and cosine recompute. angle registers sit
// at byte addresses 0 (z), 4 (y) and 8 (x), 16 bits each, 65536 per turn.
// write angles only while no word is in flight.
module point_rotate_3d_zyx_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // command side
    input  logic                                start,
    output logic                                busy,
    input  pr3d_pkg::point_in_t                 point,
    output logic                                done,
    output pr3d_pkg::point_out_t                result,
    // apb config port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pr3d_pkg::PADDR_W-1:0]        paddr,
    input  logic [pr3d_pkg::PDATA_W-1:0]        pwdata,
    output logic [pr3d_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);
    import pr3d_pkg::*;

    logic [ANGLE_W-1:0] angle_z_reg, angle_y_reg, angle_x_reg;
    logic [ANGLE_IDX_W-1:0] reg_idx;
    logic cfg_wr;
    logic [2:0] recalc;
    logic sc_busy;
    coef_t coef_z, coef_y, coef_x;

    logic accept;

    // per-axis stage outputs
    logic zr_valid, yr_valid, xr_valid;
    logic signed [INTER_W-1:0] zr_p, zr_q, zr_o;
    logic signed [INTER_W-1:0] yr_p, yr_q, yr_o;
    logic signed [INTER_W-1:0] xr_p, xr_q, xr_o;

    logic done_reg;
    point_out_t result_reg, result_next;

    // apb: write lands in the access phase, no wait states
    assign pready = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_z_reg <= '0;
            angle_y_reg <= '0;
            angle_x_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_ANGLE_Z: angle_z_reg <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_Y: angle_y_reg <= pwdata[ANGLE_W-1:0];
                REG_ANGLE_X: angle_x_reg <= pwdata[ANGLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ANGLE_Z: prdata = PDATA_W'(angle_z_reg);
            REG_ANGLE_Y: prdata = PDATA_W'(angle_y_reg);
            REG_ANGLE_X: prdata = PDATA_W'(angle_x_reg);
            default:     prdata = '0;
        endcase
    end

    // written angle needs fresh sine and cosine
    assign recalc[0] = cfg_wr && (reg_idx == REG_ANGLE_Z);
    assign recalc[1] = cfg_wr && (reg_idx == REG_ANGLE_Y);
    assign recalc[2] = cfg_wr && (reg_idx == REG_ANGLE_X);

    pr3d_sincos u_sincos (
        .clk     (clk),
        .rst_n   (rst_n),
        .recalc  (recalc),
        .angle_z (angle_z_reg),
        .angle_y (angle_y_reg),
        .angle_x (angle_x_reg),
        .coef_z  (coef_z),
        .coef_y  (coef_y),
        .coef_x  (coef_x),
        .busy    (sc_busy)
    );

    // only the coefficient refresh holds off new words
    assign busy = sc_busy;
    assign accept = start && !busy;

    // z axis: rotates (x, y), z rides along
    pr3d_rotate u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (accept),
        .src_p     (INTER_W'(point.x_in)),
        .src_q     (INTER_W'(point.y_in)),
        .src_o     (INTER_W'(point.z_in)),
        .coef      (coef_z),
        .dst_valid (zr_valid),
        .dst_p     (zr_p),
        .dst_q     (zr_q),
        .dst_o     (zr_o)
    );

    // y axis: rotates (x, z), y rides along
    pr3d_rotate u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (zr_valid),
        .src_p     (zr_p),
        .src_q     (zr_o),
        .src_o     (zr_q),
        .coef      (coef_y),
        .dst_valid (yr_valid),
        .dst_p     (yr_p),
        .dst_q     (yr_q),
        .dst_o     (yr_o)
    );

    // x axis: rotates (y, z), x rides along
    pr3d_rotate u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (yr_valid),
        .src_p     (yr_o),
        .src_q     (yr_q),
        .src_o     (yr_p),
        .coef      (coef_x),
        .dst_valid (xr_valid),
        .dst_p     (xr_p),
        .dst_q     (xr_q),
        .dst_o     (xr_o)
    );

    // intermediates keep two extra bits and are not clamped; only the final point clamps
    assign result_next.x_out = sat_coord(xr_o);
    assign result_next.y_out = sat_coord(xr_p);
    assign result_next.z_out = sat_coord(xr_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= xr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    // every accepted word comes out with done after passing the pipeline
    a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ##6 done)
        else $error("accepted word did not complete on time");

    // no result without a matching accept
    a_latency_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 7))
        else $error("result with no accepted word");

    // an angle write must hold off input while coefficients refresh
    a_wr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (reg_idx == REG_ANGLE_Z || reg_idx == REG_ANGLE_Y
            || reg_idx == REG_ANGLE_X)) |=> busy)
        else $error("angle write did not raise busy");

    // refreshed z cosine and x sine stay near unit magnitude
    a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (coef_z.cos_q <= 18'sd16400 && coef_z.cos_q >= -18'sd16400
            && coef_x.sin_q <= 18'sd16400 && coef_x.sin_q >= -18'sd16400))
        else $error("coefficient out of range");
`endif

endmodule

`default_nettype wire
